/* rtl/fbal_pkg.sv */
// ----------------------------------------------------------------------------
// fbal_pkg
// Shared types, constants and saturating helpers for the flow balance block.
// ----------------------------------------------------------------------------
package fbal_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int NODE_COUNT_BITS = 16;
    localparam int SUM_BITS        = 32 + NODE_COUNT_BITS;
    localparam int NSUM            = 7;
    localparam int IDX_W           = 3;
    localparam int DIV_W           = 64 + FRAC_BITS;
    localparam int DIV_CNT_W       = $clog2(DIV_W + 1);
    localparam int ACC_W           = 32 + 16 + 25;
    localparam int CFG_IDX_W       = 1;

    typedef enum logic [2:0] {
        ACT_JUNC   = 3'd0,
        ACT_TANK   = 3'd1,
        ACT_CLOSE  = 3'd2,
        ACT_FINISH = 3'd3,
        ACT_START  = 3'd4
    } t_action;

    localparam logic [IDX_W-1:0] S_IN   = 3'd0;
    localparam logic [IDX_W-1:0] S_OUT  = 3'd1;
    localparam logic [IDX_W-1:0] S_CONS = 3'd2;
    localparam logic [IDX_W-1:0] S_EMIT = 3'd3;
    localparam logic [IDX_W-1:0] S_LEAK = 3'd4;
    localparam logic [IDX_W-1:0] S_DEF  = 3'd5;
    localparam logic [IDX_W-1:0] S_STOR = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_PDA = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR = 1'b1;

    localparam logic RK_PERIOD = 1'b0;
    localparam logic RK_RUN    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_JUNC,
        ST_CL_DIV,
        ST_CL_WAIT,
        ST_CL_LO,
        ST_CL_HI,
        ST_CL_ACC,
        ST_FN_DIV,
        ST_FN_WAIT,
        ST_FN_BAL,
        ST_FN_RDIV,
        ST_FN_RWAIT,
        ST_DONE
    } t_state;

    function automatic logic signed [63:0] add64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            add64 = s[63:0];
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (!v[63] && v[62:31] != 32'd0) begin
            sat32 = 32'h7FFF_FFFF;
        end else if (v[63] && v[62:31] != {32{1'b1}}) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    function automatic logic [31:0] satq(input logic [DIV_W-1:0] q);
        satq = (q[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

endpackage

/* rtl/fbal_div.sv */
// ----------------------------------------------------------------------------
// fbal_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module fbal_div
    import fbal_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [63:0]      i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [63:0]          r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [63:0]          r_div;
    logic [64:0]          rem_sh;
    logic                 ge;
    logic [64:0]          rem_sub;

    assign rem_sh  = {r_rem, r_quo[DIV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_W);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // shift in next dividend bit, subtract when it fits
                r_rem <= ge ? rem_sub[63:0] : rem_sh[63:0];
                r_quo <= {r_quo[DIV_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/flow_balance_accumulator.sv */
// ----------------------------------------------------------------------------
// flow_balance_accumulator
// Sorts node flows into period sums, rolls them into run totals, reports
// period leakage and run averages.
// ----------------------------------------------------------------------------
// channel  | handshake               | payload
// input    | i_valid / o_ready       | i_action .. i_step_seconds
// result   | o_valid / i_ready       | o_result_kind .. o_balance_ratio
// config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// Junction sample: 7 steps on one saturating adder (some adds are conditional);
// tank: one add; start: clears sums and totals. Close: at most one divider pass,
// then a 24x24 multiply in two halves per sum. Finish: the bit-serial divider
// computes 7 averages plus, when needed, the ratio. One item at a time.
// Reset (synchronous) clears all sums, totals, config and control registers at once.
// A pending result holds the last step until taken; input waits meanwhile.
// ----------------------------------------------------------------------------
module flow_balance_accumulator
    import fbal_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [2:0]           i_action,
    input  logic signed [31:0]   i_demand_flow,
    input  logic signed [31:0]   i_full_demand,
    input  logic signed [31:0]   i_emitter_flow,
    input  logic signed [31:0]   i_leakage_flow,
    input  logic signed [31:0]   i_node_flow,
    input  logic                 i_is_reservoir,
    input  logic [31:0]          i_current_time,
    input  logic [23:0]          i_step_seconds,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_result_kind,
    output logic [31:0]          o_leakage_percent,
    output logic signed [31:0]   o_avg_inflow,
    output logic signed [31:0]   o_avg_outflow,
    output logic signed [31:0]   o_avg_consumer,
    output logic signed [31:0]   o_avg_emitter,
    output logic signed [31:0]   o_avg_leakage,
    output logic signed [31:0]   o_avg_deficit,
    output logic signed [31:0]   o_avg_storage,
    output logic [31:0]          o_balance_ratio,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int VW    = SUM_BITS + 2;
    localparam int NUM_W = SUM_BITS + 8;
    localparam int HI_W  = SUM_BITS - 24;

    t_state r_state, n_state;

    logic                       r_pda;
    logic [31:0]                r_dur;
    logic signed [SUM_BITS-1:0] r_psum [NSUM];
    logic signed [63:0]         r_tot  [NSUM];
    logic signed [63:0]         r_avg  [NSUM];
    logic [31:0]                r_lastleak;
    logic [31:0]                r_ratio;
    logic signed [63:0]         r_qin, r_qout;
    logic signed [ACC_W-1:0]    r_acc;
    logic [IDX_W-1:0]           r_k;
    logic [IDX_W-1:0]           r_jstep;

    logic [2:0]         r_act;
    logic signed [31:0] r_dem, r_full, r_emit, r_leak, r_node;
    logic               r_res;
    logic [31:0]        r_now;
    logic [23:0]        r_step;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [31:0] r_out_leak;
    logic [31:0] r_out_avg [NSUM];
    logic [31:0] r_out_ratio;

    // divider control
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [63:0]      div_divisor;
    logic             div_done;
    logic [DIV_W-1:0] div_q;

    fbal_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    logic in_acc, out_free;
    assign o_ready     = (r_state == ST_IDLE);
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;

    // ---------------- sample add step ----------------
    logic signed [33:0] dem34, full34, emit34, leak34, node34, diff34;
    logic               add_en;
    logic [IDX_W-1:0]   add_idx;
    logic signed [33:0] add_val;
    logic               last_jstep;

    assign dem34  = {{2{r_dem[31]}}, r_dem};
    assign full34 = {{2{r_full[31]}}, r_full};
    assign emit34 = {{2{r_emit[31]}}, r_emit};
    assign leak34 = {{2{r_leak[31]}}, r_leak};
    assign node34 = {{2{r_node[31]}}, r_node};
    assign diff34 = full34 - dem34;

    always_comb begin
        add_en     = 1'b1;
        add_idx    = S_OUT;
        add_val    = '0;
        last_jstep = 1'b0;
        if (r_act == ACT_TANK) begin
            last_jstep = 1'b1;
            if (!r_res) begin
                add_idx = S_STOR;
                add_val = node34;
            end else if (!r_node[31]) begin
                add_idx = S_OUT;
                add_val = node34;
            end else begin
                add_idx = S_IN;
                add_val = -node34;
            end
        end else begin
            unique case (r_jstep)
                3'd0: begin
                    add_idx = r_dem[31] ? S_IN : S_CONS;
                    add_val = r_dem[31] ? -dem34 : dem34;
                end
                3'd1: begin
                    add_en  = !r_dem[31];
                    add_idx = S_OUT;
                    add_val = dem34;
                end
                3'd2: begin
                    add_idx = S_EMIT;
                    add_val = emit34;
                end
                3'd3: begin
                    add_idx = S_OUT;
                    add_val = emit34;
                end
                3'd4: begin
                    add_idx = S_LEAK;
                    add_val = leak34;
                end
                3'd5: begin
                    add_idx = S_OUT;
                    add_val = leak34;
                end
                default: begin
                    last_jstep = 1'b1;
                    add_en  = r_pda && (r_full > 32'sd0) && (diff34 > 34'sd0);
                    add_idx = S_DEF;
                    add_val = diff34;
                end
            endcase
        end
    end

    logic signed [SUM_BITS-1:0] add_cur, add_res;
    logic signed [SUM_BITS:0]   add_sum;
    assign add_cur = r_psum[add_idx];
    assign add_sum = {add_cur[SUM_BITS-1], add_cur}
                   + {{(SUM_BITS+1-34){add_val[33]}}, add_val};
    always_comb begin
        if (add_sum[SUM_BITS] != add_sum[SUM_BITS-1]) begin
            add_res = add_sum[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                        : {1'b0, {(SUM_BITS-1){1'b1}}};
        end else begin
            add_res = add_sum[SUM_BITS-1:0];
        end
    end

    // ---------------- close datapath ----------------
    logic                    active;
    logic [23:0]             dt24;
    logic signed [VW-1:0]    vden;
    logic signed [NUM_W-1:0] lk, num;
    logic                    cl_divide;

    assign active = (r_dur == 32'd0) || (r_now < r_dur);
    assign dt24   = (r_dur == 32'd0) ? 24'd1 : r_step;

    always_comb begin
        vden = {{2{r_psum[S_IN][SUM_BITS-1]}}, r_psum[S_IN]};
        if (r_psum[S_STOR][SUM_BITS-1]) begin
            vden = vden - {{2{r_psum[S_STOR][SUM_BITS-1]}}, r_psum[S_STOR]};
        end
    end
    assign lk  = {{8{r_psum[S_LEAK][SUM_BITS-1]}}, r_psum[S_LEAK]};
    // times 100 as shifts: 64 + 32 + 4
    assign num = (lk <<< 6) + (lk <<< 5) + (lk <<< 2);
    assign cl_divide = (vden > 0) && (num > 0);

    logic signed [SUM_BITS-1:0] cur_k;
    logic [47:0]                p_lo;
    logic signed [HI_W+24:0]    p_hi;
    logic signed [ACC_W-1:0]    hi_ext;
    logic signed [63:0]         prod64;

    assign cur_k  = r_psum[r_k];
    assign p_lo   = cur_k[23:0] * dt24;
    assign p_hi   = $signed(cur_k[SUM_BITS-1:24]) * $signed({1'b0, dt24});
    assign hi_ext = ACC_W'(p_hi);

    always_comb begin
        if (r_acc[ACC_W-1:63] != '0 && r_acc[ACC_W-1:63] != '1) begin
            prod64 = r_acc[ACC_W-1] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            prod64 = r_acc[63:0];
        end
    end

    // ---------------- finish datapath ----------------
    logic [31:0]        secs;
    logic signed [63:0] tot_k;
    logic [63:0]        tot_mag;
    logic signed [63:0] avg_q;

    assign secs    = (r_now != 32'd0) ? r_now : 32'd1;
    assign tot_k   = r_tot[r_k];
    assign tot_mag = tot_k[63] ? (64'd0 - tot_k) : tot_k;
    assign avg_q   = tot_k[63] ? (64'sd0 - $signed(div_q[63:0])) : $signed(div_q[63:0]);

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    priority case (i_action)
                        ACT_JUNC, ACT_TANK: n_state = ST_JUNC;
                        ACT_CLOSE:          n_state = ST_CL_DIV;
                        ACT_FINISH:         n_state = ST_FN_DIV;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_JUNC:     if (last_jstep) n_state = ST_IDLE;
            ST_CL_DIV: begin
                if (!active) n_state = ST_DONE;
                else if (cl_divide) n_state = ST_CL_WAIT;
                else n_state = ST_CL_LO;
            end
            ST_CL_WAIT:  if (div_done) n_state = ST_CL_LO;
            ST_CL_LO:    n_state = ST_CL_HI;
            ST_CL_HI:    n_state = ST_CL_ACC;
            ST_CL_ACC:   n_state = (r_k == S_STOR) ? ST_DONE : ST_CL_LO;
            ST_FN_DIV:   n_state = ST_FN_WAIT;
            ST_FN_WAIT: begin
                if (div_done) n_state = (r_k == S_STOR) ? ST_FN_BAL : ST_FN_DIV;
            end
            ST_FN_BAL:   n_state = ST_FN_RDIV;
            ST_FN_RDIV: begin
                if (r_qin == r_qout) n_state = ST_DONE;
                else if (r_qin > 0 && r_qout > 0) n_state = ST_FN_RWAIT;
                else n_state = ST_DONE;
            end
            ST_FN_RWAIT: if (div_done) n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ---------------- sequencer: divider controls ----------------
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(tot_mag);
        div_divisor  = 64'(secs);
        unique case (r_state)
            ST_CL_DIV: begin
                div_start    = active && cl_divide;
                div_dividend = DIV_W'(num[NUM_W-2:0]) << FRAC_BITS;
                div_divisor  = 64'(vden[VW-2:0]);
            end
            ST_FN_DIV: begin
                div_start = 1'b1;
            end
            ST_FN_RDIV: begin
                div_start    = (r_qin != r_qout) && (r_qin > 0) && (r_qout > 0);
                div_dividend = DIV_W'(r_qout[62:0]) << FRAC_BITS;
                div_divisor  = r_qin;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // ---------------- state and datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pda       <= 1'b0;
            r_dur       <= '0;
            r_lastleak  <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_jstep     <= '0;
            for (int i = 0; i < NSUM; i++) begin
                r_psum[i] <= '0;
                r_tot[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_PDA: r_pda <= i_cfg_data[0];
                    CFG_DUR: r_dur <= i_cfg_data;
                    default: r_pda <= r_pda;
                endcase
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    r_k     <= '0;
                    r_jstep <= '0;
                    if (in_acc && i_action == ACT_START) begin
                        r_lastleak <= '0;
                        for (int i = 0; i < NSUM; i++) begin
                            r_psum[i] <= '0;
                            r_tot[i]  <= '0;
                        end
                    end
                end
                ST_JUNC: begin
                    if (add_en) r_psum[add_idx] <= add_res;
                    r_jstep <= r_jstep + 1'b1;
                end
                ST_CL_DIV: begin
                    if (active && !cl_divide) r_lastleak <= '0;
                end
                ST_CL_WAIT: begin
                    if (div_done) r_lastleak <= satq(div_q);
                end
                ST_CL_LO: begin
                    r_acc <= ACC_W'(p_lo);
                end
                ST_CL_HI: begin
                    r_acc <= r_acc + (hi_ext <<< 24);
                end
                ST_CL_ACC: begin
                    r_tot[r_k] <= add64(r_tot[r_k], prod64);
                    r_k        <= r_k + 1'b1;
                end
                ST_FN_WAIT: begin
                    if (div_done) begin
                        r_avg[r_k] <= avg_q;
                        r_k        <= r_k + 1'b1;
                    end
                end
                ST_FN_BAL: begin
                    if (r_avg[S_STOR] > 0) begin
                        r_qin  <= r_avg[S_IN];
                        r_qout <= add64(r_avg[S_OUT], r_avg[S_STOR]);
                    end else begin
                        r_qin  <= add64(r_avg[S_IN], 64'sd0 - r_avg[S_STOR]);
                        r_qout <= r_avg[S_OUT];
                    end
                end
                ST_FN_RDIV: begin
                    if (r_qin == r_qout) r_ratio <= 32'd1 << FRAC_BITS;
                    else r_ratio <= 32'd0;
                end
                ST_FN_RWAIT: begin
                    if (div_done) r_ratio <= satq(div_q);
                end
                ST_DONE: begin
                    if (out_free && r_act == ACT_CLOSE) begin
                        // drop period sums once the report is loaded for output
                        for (int i = 0; i < NSUM; i++) r_psum[i] <= '0;
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act  <= i_action;
            r_dem  <= i_demand_flow;
            r_full <= i_full_demand;
            r_emit <= i_emitter_flow;
            r_leak <= i_leakage_flow;
            r_node <= i_node_flow;
            r_res  <= i_is_reservoir;
            r_now  <= i_current_time;
            r_step <= i_step_seconds;
        end
        if (r_state == ST_DONE && out_free) begin
            if (r_act == ACT_CLOSE) begin
                r_out_kind  <= RK_PERIOD;
                r_out_leak  <= r_lastleak;
                r_out_ratio <= '0;
                for (int i = 0; i < NSUM; i++) r_out_avg[i] <= '0;
            end else begin
                r_out_kind  <= RK_RUN;
                r_out_leak  <= '0;
                r_out_ratio <= r_ratio;
                for (int i = 0; i < NSUM; i++) r_out_avg[i] <= sat32(r_avg[i]);
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_kind     = r_out_kind;
    assign o_leakage_percent = r_out_leak;
    assign o_avg_inflow      = r_out_avg[S_IN];
    assign o_avg_outflow     = r_out_avg[S_OUT];
    assign o_avg_consumer    = r_out_avg[S_CONS];
    assign o_avg_emitter     = r_out_avg[S_EMIT];
    assign o_avg_leakage     = r_out_avg[S_LEAK];
    assign o_avg_deficit     = r_out_avg[S_DEF];
    assign o_avg_storage     = r_out_avg[S_STOR];
    assign o_balance_ratio   = r_out_ratio;

endmodule
